// ----- sv/i2cee_pkg.sv -----
// Shared types, widths, command codes and reset values for the I2C EEPROM master.
// Used by the interfaces, the sequencer core, the top level and the checker.
`default_nettype none

package i2cee_pkg;

    localparam int PAGE_BYTES_DEF = 16;
    localparam int MAX_BURST_DEF  = 2048;

    localparam int CMD_W      = 3;
    localparam int ADDR_W     = 11;
    localparam int DATA_W     = 8;
    localparam int LEN_W      = 12;
    localparam int WAIT_W     = 16;
    localparam int BIT_W      = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CMD_W-1:0] CMD_TICK  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PAGE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_BURST = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_DEV_BASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAIT     = 1'b1;

    localparam logic [DATA_W-1:0] DEV_BASE_RST = 8'hA0;
    localparam logic [WAIT_W-1:0] WAIT_RST     = 16'd2000;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] mem_addr;
        logic [DATA_W-1:0] wr_data;
        logic [LEN_W-1:0]  xfer_len;
        logic              sda_in;
    } t_req;

    typedef struct packed {
        logic              scl_level;
        logic              sda_release;
        logic [DATA_W-1:0] rd_data;
        logic              rd_valid;
        logic              busy_res;
        logic              ack_missing;
        logic              done_res;
    } t_rsp;

    typedef struct packed {
        logic [DATA_W-1:0] device_base;
        logic [WAIT_W-1:0] write_wait_ticks;
    } t_cfg;

endpackage

`default_nettype wire

// ----- sv/i2cee_req_if.sv -----
// Request channel: one half-bit bus tick with the sampled SDA level and a command.
// Depends on i2cee_pkg for field widths.
`default_nettype none

interface i2cee_req_if;
    logic                          valid;
    logic                          ready;
    logic [i2cee_pkg::CMD_W-1:0]   cmd;
    logic [i2cee_pkg::ADDR_W-1:0]  mem_addr;
    logic [i2cee_pkg::DATA_W-1:0]  wr_data;
    logic [i2cee_pkg::LEN_W-1:0]   xfer_len;
    logic                          sda_in;

    modport source (output valid, cmd, mem_addr, wr_data, xfer_len, sda_in, input ready);
    modport sink   (input valid, cmd, mem_addr, wr_data, xfer_len, sda_in, output ready);
endinterface

`default_nettype wire

// ----- sv/i2cee_rsp_if.sv -----
// Result channel: bus levels, received byte and status for one tick.
// Depends on i2cee_pkg for field widths.
`default_nettype none

interface i2cee_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          scl_level;
    logic                          sda_release;
    logic [i2cee_pkg::DATA_W-1:0]  rd_data;
    logic                          rd_valid;
    logic                          busy_res;
    logic                          ack_missing;
    logic                          done_res;

    modport source (output valid, scl_level, sda_release, rd_data, rd_valid, busy_res,
                    ack_missing, done_res, input ready);
    modport sink   (input valid, scl_level, sda_release, rd_data, rd_valid, busy_res,
                    ack_missing, done_res, output ready);
endinterface

`default_nettype wire

// ----- sv/i2cee_core.sv -----
// Bus sequencer for the I2C EEPROM master: phase machine, shift logic and page buffer.
// Advances one tick per i_adv; depends on i2cee_pkg.
`default_nettype none

module i2cee_core #(
    parameter int PAGE_BYTES = i2cee_pkg::PAGE_BYTES_DEF,
    parameter int MAX_BURST  = i2cee_pkg::MAX_BURST_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_adv,
    input  wire i2cee_pkg::t_req i_req,
    input  wire i2cee_pkg::t_cfg i_cfg,
    output i2cee_pkg::t_rsp      o_rsp
);

    localparam int PF_W  = $clog2(PAGE_BYTES + 1);
    localparam int IDX_W = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;
    localparam int LW    = i2cee_pkg::LEN_W;
    localparam int BW    = i2cee_pkg::BIT_W;

    typedef enum logic [9:0] {
        PH_IDLE   = 10'b00_0000_0001,
        PH_START  = 10'b00_0000_0010,
        PH_DEVW   = 10'b00_0000_0100,
        PH_ADDR   = 10'b00_0000_1000,
        PH_DATA   = 10'b00_0001_0000,
        PH_RSTART = 10'b00_0010_0000,
        PH_DEVR   = 10'b00_0100_0000,
        PH_RX     = 10'b00_1000_0000,
        PH_STOP   = 10'b01_0000_0000,
        PH_WAIT   = 10'b10_0000_0000
    } t_phase;

    t_phase                          r_phase, n_phase;
    logic [7:0]                      r_shift, n_shift;
    logic [BW-1:0]                   r_bit, n_bit;
    logic                            r_half, n_half;
    logic [LW-1:0]                   r_left, n_left;
    logic [i2cee_pkg::WAIT_W-1:0]    r_wait, n_wait;
    logic [PF_W-1:0]                 r_fill, n_fill;
    logic [PF_W-1:0]                 r_pos, n_pos;
    logic [i2cee_pkg::ADDR_W-1:0]    r_addr, n_addr;
    logic [i2cee_pkg::CMD_W-1:0]     r_op, n_op;
    logic [7:0]                      r_data, n_data;

    logic [7:0]                      r_page [PAGE_BYTES];
    logic [7:0]                      r_pref;
    logic [PF_W-1:0]                 w_pref_addr;
    logic                            w_mem_we;
    logic [7:0]                      w_dev;
    logic                            w_is_wr;

    assign w_pref_addr = (r_phase == PH_DATA) ? PF_W'(r_pos + 1'b1) : r_pos;
    assign w_dev = i_cfg.device_base | {4'b0, r_addr[10:8], 1'b0};
    assign w_is_wr = (r_op == i2cee_pkg::CMD_WRITE) || (r_op == i2cee_pkg::CMD_PAGE);

    always_ff @(posedge i_clk) begin
        if (i_adv && w_mem_we) begin
            r_page[r_fill[IDX_W-1:0]] <= i_req.wr_data;
        end
        if (w_pref_addr < PF_W'(PAGE_BYTES)) begin
            r_pref <= r_page[w_pref_addr[IDX_W-1:0]];
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_shift = r_shift;
        n_bit   = r_bit;
        n_half  = r_half;
        n_left  = r_left;
        n_wait  = r_wait;
        n_fill  = r_fill;
        n_pos   = r_pos;
        n_addr  = r_addr;
        n_op    = r_op;
        n_data  = r_data;
        w_mem_we = 1'b0;
        o_rsp = '0;
        o_rsp.scl_level   = 1'b1;
        o_rsp.sda_release = 1'b1;

        if (r_phase == PH_IDLE) begin
            if (i_req.cmd == i2cee_pkg::CMD_LOAD) begin
                if (r_fill < PF_W'(PAGE_BYTES)) begin
                    w_mem_we = 1'b1;
                    n_fill   = PF_W'(r_fill + 1'b1);
                end
            end else if (i_req.cmd == i2cee_pkg::CMD_WRITE || i_req.cmd == i2cee_pkg::CMD_PAGE ||
                         i_req.cmd == i2cee_pkg::CMD_READ || i_req.cmd == i2cee_pkg::CMD_BURST) begin
                n_op   = i_req.cmd;
                n_addr = i_req.mem_addr;
                n_data = i_req.wr_data;
                n_pos  = '0;
                if (i_req.cmd == i2cee_pkg::CMD_PAGE) begin
                    n_left = (32'(i_req.xfer_len) < PAGE_BYTES) ? i_req.xfer_len : LW'(PAGE_BYTES);
                    n_fill = '0;
                end else if (i_req.cmd == i2cee_pkg::CMD_BURST) begin
                    n_left = (32'(i_req.xfer_len) < MAX_BURST) ? i_req.xfer_len : LW'(MAX_BURST);
                end else begin
                    n_left = LW'(1);
                end
                n_phase = PH_START;
                n_shift = '0;
                n_bit   = '0;
                n_half  = 1'b0;
            end
        end

        o_rsp.busy_res = (n_phase != PH_IDLE);

        case (n_phase)
            PH_IDLE: begin
                o_rsp.scl_level   = 1'b1;
                o_rsp.sda_release = 1'b1;
            end
            PH_START, PH_RSTART: begin
                if (n_bit == BW'(0)) begin
                    o_rsp.scl_level = 1'b0;
                    n_bit = BW'(1);
                end else if (n_bit == BW'(1)) begin
                    n_bit = BW'(2);
                end else begin
                    o_rsp.sda_release = 1'b0;
                    n_bit  = '0;
                    n_half = 1'b0;
                    if (n_phase == PH_START) begin
                        n_phase = PH_DEVW;
                        n_shift = w_dev;
                    end else begin
                        n_phase = PH_DEVR;
                        n_shift = w_dev | 8'h01;
                    end
                end
            end
            PH_DEVW, PH_ADDR, PH_DATA, PH_DEVR: begin
                o_rsp.scl_level   = n_half;
                o_rsp.sda_release = (n_bit < BW'(8)) ? n_shift[3'(3'd7 - n_bit[2:0])] : 1'b1;
                if (!n_half) begin
                    n_half = 1'b1;
                end else if (n_bit < BW'(8)) begin
                    n_bit  = BW'(n_bit + 1'b1);
                    n_half = 1'b0;
                end else begin
                    o_rsp.ack_missing = i_req.sda_in;
                    n_bit  = '0;
                    n_half = 1'b0;
                    n_shift = '0;
                    case (n_phase)
                        PH_DEVW: begin
                            n_phase = PH_ADDR;
                            n_shift = n_addr[7:0];
                        end
                        PH_ADDR: begin
                            if (n_op == i2cee_pkg::CMD_WRITE) begin
                                n_phase = PH_DATA;
                                n_shift = n_data;
                            end else if (n_op == i2cee_pkg::CMD_PAGE) begin
                                if (n_left != '0) begin
                                    n_phase = PH_DATA;
                                    n_shift = r_pref;
                                end else begin
                                    n_phase = PH_STOP;
                                end
                            end else begin
                                n_phase = PH_RSTART;
                            end
                        end
                        PH_DATA: begin
                            if (n_left != '0) begin
                                n_left = LW'(n_left - 1'b1);
                            end
                            n_pos = PF_W'(n_pos + 1'b1);
                            if (n_left != '0 && n_op == i2cee_pkg::CMD_PAGE) begin
                                n_phase = PH_DATA;
                                n_shift = r_pref;
                            end else begin
                                n_phase = PH_STOP;
                            end
                        end
                        default: begin
                            n_phase = (n_left != '0) ? PH_RX : PH_STOP;
                        end
                    endcase
                end
            end
            PH_RX: begin
                o_rsp.scl_level   = n_half;
                o_rsp.sda_release = (n_bit < BW'(8)) ? 1'b1 : !(n_left > LW'(1));
                if (!n_half) begin
                    n_half = 1'b1;
                end else if (n_bit < BW'(8)) begin
                    n_shift = {n_shift[6:0], i_req.sda_in};
                    if (n_bit == BW'(7)) begin
                        o_rsp.rd_data  = n_shift;
                        o_rsp.rd_valid = 1'b1;
                    end
                    n_bit  = BW'(n_bit + 1'b1);
                    n_half = 1'b0;
                end else begin
                    if (n_left != '0) begin
                        n_left = LW'(n_left - 1'b1);
                    end
                    n_phase = (n_left != '0) ? PH_RX : PH_STOP;
                    n_shift = '0;
                    n_bit   = '0;
                    n_half  = 1'b0;
                end
            end
            PH_STOP: begin
                if (n_bit == BW'(0)) begin
                    o_rsp.scl_level   = 1'b0;
                    o_rsp.sda_release = 1'b0;
                    n_bit = BW'(1);
                end else if (n_bit == BW'(1)) begin
                    o_rsp.sda_release = 1'b0;
                    n_bit = BW'(2);
                end else begin
                    n_bit  = '0;
                    n_half = 1'b0;
                    n_shift = '0;
                    if (w_is_wr && i_cfg.write_wait_ticks != '0) begin
                        n_phase = PH_WAIT;
                        n_wait  = i_cfg.write_wait_ticks;
                    end else begin
                        n_phase = PH_IDLE;
                        o_rsp.done_res = 1'b1;
                    end
                end
            end
            PH_WAIT: begin
                if (n_wait != '0) begin
                    n_wait = n_wait - 1'b1;
                end
                if (n_wait == '0) begin
                    n_phase = PH_IDLE;
                    n_shift = '0;
                    n_bit   = '0;
                    n_half  = 1'b0;
                    o_rsp.done_res = 1'b1;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_shift <= '0;
            r_bit   <= '0;
            r_half  <= 1'b0;
            r_left  <= '0;
            r_wait  <= '0;
            r_fill  <= '0;
            r_pos   <= '0;
            r_addr  <= '0;
            r_op    <= '0;
            r_data  <= '0;
        end else if (i_adv) begin
            r_phase <= n_phase;
            r_shift <= n_shift;
            r_bit   <= n_bit;
            r_half  <= n_half;
            r_left  <= n_left;
            r_wait  <= n_wait;
            r_fill  <= n_fill;
            r_pos   <= n_pos;
            r_addr  <= n_addr;
            r_op    <= n_op;
            r_data  <= n_data;
        end
    end

endmodule

`default_nettype wire

// ----- sv/i2c_eeprom_master.sv -----
// I2C master for a 24C16-style EEPROM, one request per half-bit bus tick, one result
// per request. A request is registered, stepped through the bus sequencer and its
// result lands in an output register, so a new request is taken every clock while
// the result side keeps up. The sequencer state loop (phase, shift byte, counters)
// sets the one-tick-per-clock rate. Depends on i2cee_pkg, i2cee_req_if, i2cee_rsp_if
// and i2cee_core.
`default_nettype none

module i2c_eeprom_master #(
    parameter int PAGE_BYTES = i2cee_pkg::PAGE_BYTES_DEF,
    parameter int MAX_BURST  = i2cee_pkg::MAX_BURST_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    i2cee_req_if.sink                                i_req,
    i2cee_rsp_if.source                              o_rsp,
    input  wire logic                                i_cfg_we,
    input  wire logic [i2cee_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [i2cee_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    i2cee_pkg::t_cfg r_cfg;
    i2cee_pkg::t_req r_in;
    i2cee_pkg::t_rsp r_out;
    i2cee_pkg::t_rsp w_step;
    logic            r_in_valid;
    logic            r_out_valid;
    logic            w_adv;
    logic            w_take;

    assign w_adv       = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || w_adv;
    assign w_take      = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.device_base      <= i2cee_pkg::DEV_BASE_RST;
            r_cfg.write_wait_ticks <= i2cee_pkg::WAIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                i2cee_pkg::CFG_DEV_BASE: r_cfg.device_base      <= i_cfg_data[7:0];
                i2cee_pkg::CFG_WAIT:     r_cfg.write_wait_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in.cmd      <= i_req.cmd;
            r_in.mem_addr <= i_req.mem_addr;
            r_in.wr_data  <= i_req.wr_data;
            r_in.xfer_len <= i_req.xfer_len;
            r_in.sda_in   <= i_req.sda_in;
        end
        if (w_adv) begin
            r_out <= w_step;
        end
    end

    i2cee_core #(
        .PAGE_BYTES (PAGE_BYTES),
        .MAX_BURST  (MAX_BURST)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_req   (r_in),
        .i_cfg   (r_cfg),
        .o_rsp   (w_step)
    );

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.scl_level   = r_out.scl_level;
    assign o_rsp.sda_release = r_out.sda_release;
    assign o_rsp.rd_data     = r_out.rd_data;
    assign o_rsp.rd_valid    = r_out.rd_valid;
    assign o_rsp.busy_res    = r_out.busy_res;
    assign o_rsp.ack_missing = r_out.ack_missing;
    assign o_rsp.done_res    = r_out.done_res;

endmodule

`default_nettype wire

// ----- sv/i2cee_chk.sv -----
// Port-level checker for the I2C EEPROM master, bound to the top level.
// Watches the result channel only; depends on i2cee_pkg.
`default_nettype none

module i2cee_chk (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_valid,
    input wire logic                          i_ready,
    input wire logic                          i_scl,
    input wire logic                          i_sda,
    input wire logic [i2cee_pkg::DATA_W-1:0]  i_rd_data,
    input wire logic                          i_rd_valid,
    input wire logic                          i_busy,
    input wire logic                          i_ackm,
    input wire logic                          i_done
);

    a_rd_in_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_rd_valid || i_done) |-> i_busy)
        else $error("received byte or done outside a transaction");

    a_rd_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_rd_valid |-> i_rd_data == '0)
        else $error("read data set without a received byte");

    a_ack_on_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_ackm || i_rd_valid) |-> i_scl && i_sda)
        else $error("ack or sample outside SCL high with SDA released");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_rd_data) && $stable(i_done)
            && $stable(i_scl) && $stable(i_sda))
        else $error("stalled result changed");

endmodule

bind i2c_eeprom_master i2cee_chk u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (o_rsp.valid),
    .i_ready    (o_rsp.ready),
    .i_scl      (o_rsp.scl_level),
    .i_sda      (o_rsp.sda_release),
    .i_rd_data  (o_rsp.rd_data),
    .i_rd_valid (o_rsp.rd_valid),
    .i_busy     (o_rsp.busy_res),
    .i_ackm     (o_rsp.ack_missing),
    .i_done     (o_rsp.done_res)
);

`default_nettype wire
